// ===== src/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfd_pkg - shared types and constants of the WebSocket frame deframer
// Result codes, header constants and the item carried from parser to output.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	// width of the maximum payload length register
	localparam int unsigned CFG_W = 21;

	// defaults for top-level parameters
	localparam logic [31:0] MAX_PAYLOAD_DEFAULT = 32'd1048576;
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_RSV   = 2'd2;
	localparam logic [1:0] KIND_BIG   = 2'd3;

	// header byte fields
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	// one classified result on its way from parser to output stage
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;    // raw stream byte, zero for non-data kinds
		logic [7:0] key;     // mask key byte to apply, zero when unmasked
		logic [3:0] opcode;
		logic       fin;
		logic       last;
	} wsfd_item_t;

	localparam int unsigned ITEM_W = $bits(wsfd_item_t);

	// parser status seen by the top level
	typedef struct packed {
		logic err;           // sticky error latched
		logic in_payload;    // inside a frame payload
	} wsfd_status_t;

endpackage

// ===== src/wsfd_front.sv =====
// ----------------------------------------------------------------------------
// wsfd_front - frame header parser
// Walks each frame byte by byte and turns payload bytes, empty-frame ends and errors into result items.
// ----------------------------------------------------------------------------
module wsfd_front import wsfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       stream_byte,
	input  logic [CFG_W-1:0] limit,
	output logic             item_valid,
	output wsfd_item_t       item,
	output wsfd_status_t     status
);

	localparam logic [2:0] PH_HDR0   = 3'd0;
	localparam logic [2:0] PH_HDR1   = 3'd1;
	localparam logic [2:0] PH_EXTLEN = 3'd2;
	localparam logic [2:0] PH_KEY    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_ERROR  = 3'd5;

	logic [2:0]       phase_q;
	logic [63:0]      len_acc_q;
	logic [3:0]       hdr_left_q;
	logic [31:0]      mask_key_q;
	logic             is_masked_q;
	logic             fin_q;
	logic [3:0]       opcode_q;
	logic [1:0]       key_pos_q;
	logic [CFG_W-1:0] bytes_rem_q;

	logic [63:0] len_now;
	logic        len_done;
	logic        too_big;
	logic        len_zero;
	logic        mask_now;
	logic        key_done;
	logic [7:0]  key_byte;

	always_comb begin
		len_now  = (phase_q == PH_HDR1) ? {57'd0, stream_byte[6:0]}
		                                : {len_acc_q[55:0], stream_byte};
		len_done = ((phase_q == PH_HDR1) && (stream_byte[6:0] != LEN_EXT16)
		            && (stream_byte[6:0] != LEN_EXT64))
		        || ((phase_q == PH_EXTLEN) && (hdr_left_q == 4'd1));
		too_big  = (|len_now[63:CFG_W]) || (len_now[CFG_W-1:0] > limit);
		len_zero = (len_now[CFG_W-1:0] == '0);
		mask_now = (phase_q == PH_HDR1) ? stream_byte[7] : is_masked_q;
		key_done = (phase_q == PH_KEY) && (hdr_left_q == 4'd1);
		key_byte = mask_key_q[8*(3-key_pos_q) +: 8];
	end

	// classify the byte
	always_comb begin
		item_valid = 1'b0;
		item       = '0;
		unique case (phase_q)
			PH_HDR0: begin
				if (stream_byte[6:4] != 3'd0) begin
					item_valid = 1'b1;
					item.kind  = KIND_RSV;
					item.fin   = stream_byte[7];
				end
			end
			PH_HDR1, PH_EXTLEN: begin
				if (len_done) begin
					if (too_big) begin
						item_valid  = 1'b1;
						item.kind   = KIND_BIG;
						item.opcode = opcode_q;
						item.fin    = fin_q;
					end else if (!mask_now && len_zero) begin
						item_valid  = 1'b1;
						item.kind   = KIND_EMPTY;
						item.opcode = opcode_q;
						item.fin    = fin_q;
						item.last   = 1'b1;
					end
				end
			end
			PH_KEY: begin
				if (key_done && (bytes_rem_q == '0)) begin
					item_valid  = 1'b1;
					item.kind   = KIND_EMPTY;
					item.opcode = opcode_q;
					item.fin    = fin_q;
					item.last   = 1'b1;
				end
			end
			PH_DATA: begin
				item_valid  = 1'b1;
				item.kind   = KIND_DATA;
				item.data   = stream_byte;
				item.key    = is_masked_q ? key_byte : 8'd0;
				item.opcode = opcode_q;
				item.fin    = fin_q;
				item.last   = (bytes_rem_q == CFG_W'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			len_acc_q   <= '0;
			hdr_left_q  <= '0;
			mask_key_q  <= '0;
			is_masked_q <= 1'b0;
			fin_q       <= 1'b0;
			opcode_q    <= '0;
			key_pos_q   <= '0;
			bytes_rem_q <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HDR0: begin
					fin_q <= stream_byte[7];
					if (stream_byte[6:4] != 3'd0) begin
						phase_q <= PH_ERROR;
					end else begin
						opcode_q <= stream_byte[3:0];
						phase_q  <= PH_HDR1;
					end
				end
				PH_HDR1, PH_EXTLEN: begin
					if (phase_q == PH_HDR1) begin
						is_masked_q <= stream_byte[7];
					end else begin
						len_acc_q  <= len_now;
						hdr_left_q <= hdr_left_q - 4'd1;
					end
					if (!len_done) begin
						// extended length follows
						if (phase_q == PH_HDR1) begin
							hdr_left_q <= (stream_byte[6:0] == LEN_EXT16) ? EXT16_BYTES
							                                               : EXT64_BYTES;
							len_acc_q  <= '0;
							phase_q    <= PH_EXTLEN;
						end
					end else if (too_big) begin
						phase_q <= PH_ERROR;
					end else begin
						bytes_rem_q <= len_now[CFG_W-1:0];
						mask_key_q  <= '0;
						if (mask_now) begin
							hdr_left_q <= KEY_BYTES;
							phase_q    <= PH_KEY;
						end else begin
							key_pos_q <= '0;
							phase_q   <= len_zero ? PH_HDR0 : PH_DATA;
						end
					end
				end
				PH_KEY: begin
					mask_key_q <= {mask_key_q[23:0], stream_byte};
					hdr_left_q <= hdr_left_q - 4'd1;
					if (key_done) begin
						key_pos_q <= '0;
						phase_q   <= (bytes_rem_q == '0) ? PH_HDR0 : PH_DATA;
					end
				end
				PH_DATA: begin
					key_pos_q   <= key_pos_q + 2'd1;
					bytes_rem_q <= bytes_rem_q - CFG_W'(1);
					if (bytes_rem_q == CFG_W'(1)) begin
						phase_q <= PH_HDR0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign status.err        = (phase_q == PH_ERROR);
	assign status.in_payload = (phase_q == PH_DATA);

endmodule

// ===== src/wsfd_queue.sv =====
// ----------------------------------------------------------------------------
// wsfd_queue - short result queue between parser and output stage
// Register-based FIFO with a combinational head.
// ----------------------------------------------------------------------------
module wsfd_queue import wsfd_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  wsfd_item_t wr_item,
	input  logic       rd,
	output wsfd_item_t rd_item,
	output logic       full,
	output logic       nonempty
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	wsfd_item_t       slots_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign nonempty = (count_q != '0);
	assign rd_item  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/wsfd_back.sv =====
// ----------------------------------------------------------------------------
// wsfd_back - unmasking and result register
// Applies the mask key to payload bytes and holds the oldest result.
// ----------------------------------------------------------------------------
module wsfd_back import wsfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_nonempty,
	input  wsfd_item_t q_item,
	output logic       q_take,
	input  logic       pop,
	output logic       empty,
	output logic [1:0] result_kind,
	output logic [7:0] payload_byte,
	output logic [3:0] frame_opcode,
	output logic       final_fragment,
	output logic       last_of_frame
);

	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic [3:0] opcode_q;
	logic       fin_q;
	logic       last_q;

	// refill when the register is free or its result leaves this cycle
	assign q_take = q_nonempty && (!valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			kind_q   <= q_item.kind;
			byte_q   <= q_item.data ^ q_item.key;
			opcode_q <= q_item.opcode;
			fin_q    <= q_item.fin;
			last_q   <= q_item.last;
		end
	end

	assign empty          = !valid_q;
	assign result_kind    = kind_q;
	assign payload_byte   = byte_q;
	assign frame_opcode   = opcode_q;
	assign final_fragment = fin_q;
	assign last_of_frame  = last_q;

endmodule

// ===== src/websocket_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit - WebSocket receive-side frame deframer
// Parses a framed byte stream and delivers unmasked payload bytes, empty-frame ends and errors.
// ----------------------------------------------------------------------------
// Feed the received stream one byte per transfer on push/full and drain
// results on empty/pop. The block takes one byte every cycle while full is
// low; full rises only when QUEUE_DEPTH results back up behind a
// stalled consumer. A result passes from the header parser into the
// result queue and then through the unmasking result register. Header
// bytes give no result, except that a header completing an
// empty frame gives one empty-frame end and an offending header byte gives
// an error. Reserved bits set, or a length above the smaller of cfg_wr_data
// and MAX_PAYLOAD, raise an error once; after that every byte is consumed
// silently until reset. Write the limit only while the block is idle; it is
// sampled when a frame's length field completes.
module websocket_frame_deframer_unit import wsfd_pkg::*; #(
	parameter logic [31:0] MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT,
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	// byte stream in
	input  logic             push,
	output logic             full,
	input  logic [7:0]       stream_byte,
	// results out
	output logic             empty,
	input  logic             pop,
	output logic [1:0]       result_kind,
	output logic [7:0]       payload_byte,
	output logic [3:0]       frame_opcode,
	output logic             final_fragment,
	output logic             last_of_frame,
	// length limit register
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data
);

	// cap of the limit set by the parameter, clipped to the register width
	localparam logic [CFG_W-1:0] LIMIT_CAP =
		(MAX_PAYLOAD > 32'((64'd1 << CFG_W) - 64'd1)) ? '1 : MAX_PAYLOAD[CFG_W-1:0];

	logic [CFG_W-1:0] max_len_q;
	logic [CFG_W-1:0] limit;
	logic             accept;
	logic             item_valid;
	wsfd_item_t       item;
	wsfd_status_t     status;
	wsfd_item_t       q_item;
	logic             q_full;
	logic             q_nonempty;
	logic             q_take;

	// limit register: the parameter also sets its reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_PAYLOAD[CFG_W-1:0];
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	assign limit  = (max_len_q < LIMIT_CAP) ? max_len_q : LIMIT_CAP;
	assign full   = q_full;
	assign accept = push && !q_full;

	wsfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.stream_byte (stream_byte),
		.limit       (limit),
		.item_valid  (item_valid),
		.item        (item),
		.status      (status)
	);

	// push a result only for a byte that is actually taken
	wsfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (accept && item_valid),
		.wr_item  (item),
		.rd       (q_take),
		.rd_item  (q_item),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	wsfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_nonempty     (q_nonempty),
		.q_item         (q_item),
		.q_take         (q_take),
		.pop            (pop),
		.empty          (empty),
		.result_kind    (result_kind),
		.payload_byte   (payload_byte),
		.frame_opcode   (frame_opcode),
		.final_fragment (final_fragment),
		.last_of_frame  (last_of_frame)
	);

`ifndef SYNTHESIS
	// the error is sticky until reset
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status.err |=> status.err)
		else $error("sticky error cleared");

	// once in error, accepted bytes produce nothing
	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(status.err && accept) |-> !item_valid)
		else $error("result produced in error state");

	// every payload byte is classified as data
	a_payload_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status.in_payload) |-> (item_valid && (item.kind == KIND_DATA)))
		else $error("payload byte not classified as data");

	// error results never mark an end of frame
	a_err_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && ((result_kind == KIND_RSV) || (result_kind == KIND_BIG)))
			|-> (!last_of_frame && (payload_byte == 8'd0)))
		else $error("error result with frame end or data");
`endif

endmodule

// ===== verif/tb_websocket_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer_unit - self-checking bench of the frame deframer
// A directed table of header and payload bytes opens the run. Random
// well-formed frames follow under a series of length limits. A single error
// frame closes it, since the error state only clears on reset. Each result is
// checked against the bench's byte-level parser or a directed row's result.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_unit import wsfd_pkg::*; ();

	localparam int unsigned MAX_LEN       = MAX_PAYLOAD_DEFAULT;
	localparam int unsigned N_PHASES      = 8;
	localparam int unsigned PHASE_BYTES   = 178;
	localparam int unsigned STEADY_PHASE  = 4;   // both sides run without a break
	localparam int unsigned SETTLE_CYCLES = 4;   // margin after the last due result has come out
	localparam int unsigned SHOWN_ERRORS  = 40;

	// table layout: directed rows, then the two alternative closing frames
	localparam int unsigned DIRECTED_END = 29;
	localparam int unsigned RSV_TAIL_END = 32;
	localparam int unsigned TABLE_ROWS   = 44;

	// parser model phases
	localparam logic [2:0] PH_HDR0   = 3'd0;
	localparam logic [2:0] PH_HDR1   = 3'd1;
	localparam logic [2:0] PH_EXTLEN = 3'd2;
	localparam logic [2:0] PH_KEY    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_ERROR  = 3'd5;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [3:0] opcode;
		logic       fin;
		logic       last;
	} frame_result_t;

	typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} exp_mode_t;

	typedef struct {
		logic [7:0]    b;
		exp_mode_t     mode;
		frame_result_t given;
	} stim_row_t;

	localparam frame_result_t NO_RESULT = '0;

	logic             clk;
	logic             arst_n      = 1'b0;
	logic             push        = 1'b0;
	logic [7:0]       stream_byte = '0;
	logic             pop         = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;
	logic             full;
	logic             empty;
	logic [1:0]       result_kind;
	logic [7:0]       payload_byte;
	logic [3:0]       frame_opcode;
	logic             final_fragment;
	logic             last_of_frame;

	// bench copy of the parser state and of the limit register
	logic [2:0]   pr_phase     = PH_HDR0;
	logic [63:0]  pr_len       = '0;
	logic [3:0]   pr_hdr_left  = '0;
	logic [31:0]  pr_key       = '0;
	logic         pr_masked    = 1'b0;
	logic         pr_fin       = 1'b0;
	logic [3:0]   pr_opcode    = '0;
	logic [1:0]   pr_key_pos   = '0;
	logic [20:0]  pr_remaining = '0;
	logic         pr_error     = 1'b0;
	logic [20:0]  pr_limit     = 21'(MAX_LEN);

	frame_result_t results_due [$];
	logic [7:0]    stream_q [$];
	int unsigned   mismatch_count = 0;
	bit            steady = 1'b0;

	// Directed bytes. Rows marked EXP_GIVEN carry the result by hand, EXP_NONE
	// rows must give nothing, EXP_MODEL rows are left to the parser model.
	stim_row_t stim_table [TABLE_ROWS] = '{
		// unmasked empty frame, FIN set, text opcode
		'{8'h81, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_GIVEN, '{KIND_EMPTY, 8'h00, 4'h1, 1'b1, 1'b1}},
		// masked empty frame, FIN clear, top opcode: ends after the key
		'{8'h0F, EXP_NONE,  NO_RESULT},
		'{8'h80, EXP_NONE,  NO_RESULT},
		'{8'hFF, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'hFF, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_GIVEN, '{KIND_EMPTY, 8'h00, 4'hF, 1'b0, 1'b1}},
		// masked frame, 16-bit length of two
		'{8'h82, EXP_NONE,  NO_RESULT},
		'{8'hFE, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'h02, EXP_NONE,  NO_RESULT},
		'{8'hA5, EXP_NONE,  NO_RESULT},
		'{8'h5A, EXP_NONE,  NO_RESULT},
		'{8'h3C, EXP_NONE,  NO_RESULT},
		'{8'hC3, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_MODEL, NO_RESULT},
		'{8'hFF, EXP_MODEL, NO_RESULT},
		// unmasked frame, 64-bit length of one: the byte passes unchanged
		'{8'h0A, EXP_NONE,  NO_RESULT},
		'{8'h7F, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'h01, EXP_NONE,  NO_RESULT},
		'{8'hFF, EXP_GIVEN, '{KIND_DATA, 8'hFF, 4'hA, 1'b0, 1'b1}},
		// closing frame, first choice: a reserved bit set, then silence
		'{8'hC5, EXP_GIVEN, '{KIND_RSV, 8'h00, 4'h0, 1'b1, 1'b0}},
		'{8'h81, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		// closing frame, second choice: 64-bit length with the top bit set
		'{8'h02, EXP_NONE,  NO_RESULT},
		'{8'hFF, EXP_NONE,  NO_RESULT},
		'{8'h80, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_GIVEN, '{KIND_BIG, 8'h00, 4'h2, 1'b0, 1'b0}},
		'{8'h81, EXP_NONE,  NO_RESULT},
		'{8'h00, EXP_NONE,  NO_RESULT}
	};

	websocket_frame_deframer_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.stream_byte   (stream_byte),
		.empty         (empty),
		.pop           (pop),
		.result_kind   (result_kind),
		.payload_byte  (payload_byte),
		.frame_opcode  (frame_opcode),
		.final_fragment(final_fragment),
		.last_of_frame (last_of_frame),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------------
	// Frame parser model
	// ------------------------------------------------------------------------

	// the limit in force is the smaller of the register and the build limit
	function automatic int unsigned applied_limit(input logic [20:0] reg_v);
		return (int'(reg_v) < MAX_LEN) ? int'(reg_v) : MAX_LEN;
	endfunction

	// latch the sticky error and hand back its one result
	function automatic bit raise_error(input logic [1:0] kind, input logic [3:0] op,
			output frame_result_t res);
		pr_error = 1'b1;
		pr_phase = PH_ERROR;
		res = '{kind, 8'h00, op, pr_fin, 1'b0};
		return 1'b1;
	endfunction

	// header complete: enter the payload, or close an empty frame at once
	function automatic bit finish_header(output frame_result_t res);
		res = NO_RESULT;
		pr_key_pos = '0;
		if (pr_remaining == '0) begin
			pr_phase = PH_HDR0;
			res = '{KIND_EMPTY, 8'h00, pr_opcode, pr_fin, 1'b1};
			return 1'b1;
		end
		pr_phase = PH_DATA;
		return 1'b0;
	endfunction

	// length complete: the limit is sampled here and nowhere else
	function automatic bit finish_length(output frame_result_t res);
		res = NO_RESULT;
		if (pr_len > 64'(applied_limit(pr_limit)))
			return raise_error(KIND_BIG, pr_opcode, res);
		pr_remaining = pr_len[20:0];
		pr_key = '0;
		if (pr_masked) begin
			pr_phase = PH_KEY;
			pr_hdr_left = KEY_BYTES;
			return 1'b0;
		end
		return finish_header(res);
	endfunction

	// advance the parser by one stream byte; returns 1 when a result is due
	function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t res);
		logic [7:0] data;
		res = NO_RESULT;
		if (pr_error)
			return 1'b0;
		case (pr_phase)
			PH_HDR0: begin
				pr_fin = b[7];
				if (b[6:4] != 3'b000)
					return raise_error(KIND_RSV, 4'h0, res);
				pr_opcode = b[3:0];
				pr_phase = PH_HDR1;
			end
			PH_HDR1: begin
				pr_masked = b[7];
				if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
					pr_hdr_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
					pr_len = '0;
					pr_phase = PH_EXTLEN;
				end else begin
					pr_len = 64'(b[6:0]);
					return finish_length(res);
				end
			end
			PH_EXTLEN: begin
				pr_len = {pr_len[55:0], b};
				pr_hdr_left = pr_hdr_left - 4'd1;
				if (pr_hdr_left == '0)
					return finish_length(res);
			end
			PH_KEY: begin
				pr_key = {pr_key[23:0], b};
				pr_hdr_left = pr_hdr_left - 4'd1;
				if (pr_hdr_left == '0)
					return finish_header(res);
			end
			PH_DATA: begin
				data = b;
				// key bytes apply most significant first, rotating every four
				if (pr_masked)
					data = data ^ 8'(pr_key >> (8 * (3 - int'(pr_key_pos))));
				pr_key_pos = pr_key_pos + 2'd1;
				if (pr_remaining != '0)
					pr_remaining = pr_remaining - 21'd1;
				res = '{KIND_DATA, data, pr_opcode, pr_fin, pr_remaining == '0};
				if (pr_remaining == '0)
					pr_phase = PH_HDR0;
				return 1'b1;
			end
			default: ;
		endcase
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// a break is drawn with a chance of roughly one in eight, except in the steady stretch
	function automatic bit stall_now();
		return !steady && ($urandom_range(99) < 12);
	endfunction

	// Offer one byte from the falling edge; hold it until a transfer, then
	// queue whatever result it is due to produce.
	task automatic send_byte(input logic [7:0] b, input exp_mode_t mode,
			input frame_result_t given);
		frame_result_t res;
		bit            due;
		while (stall_now()) begin
			push <= 1'b0;
			stream_byte <= 8'($urandom);
			@(negedge clk);
		end
		push <= 1'b1;
		stream_byte <= b;
		do
			@(posedge clk);
		while (full);
		due = deframe_byte(b, res);
		if (mode == EXP_GIVEN)
			results_due.push_back(given);
		else if (mode == EXP_MODEL && due)
			results_due.push_back(res);
		@(negedge clk);
	endtask

	// hold off the sender until every queued result has come out
	task automatic drain_results();
		push <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		pr_limit = value;
	endtask

	// Append one well-formed frame to the stream, length no more than cap.
	// Reserved bits stay clear: the error path only clears on reset, so it
	// is taken once, by the closing frame.
	task automatic build_frame(input int unsigned cap);
		int unsigned len;
		int unsigned roll;
		logic [31:0] key;
		bit          masked;
		roll = $urandom_range(99);
		if (roll < 8 && cap >= 126)
			len = $urandom_range(126, (cap < 400) ? cap : 400);
		else if (roll < 20)
			len = (cap < 20) ? cap : 20;   // often exactly the limit when it is small
		else
			len = $urandom_range(0, (cap < 20) ? cap : 20);
		masked = 1'($urandom_range(1));
		key = $urandom;
		stream_q.push_back({1'($urandom_range(1)), 3'b000, 4'($urandom)});
		// short lengths may still use the wider encodings
		if (len < 126 && $urandom_range(99) < 70) begin
			stream_q.push_back({masked, 7'(len)});
		end else if ($urandom_range(1) == 1) begin
			stream_q.push_back({masked, LEN_EXT16});
			stream_q.push_back(8'(len >> 8));
			stream_q.push_back(8'(len));
		end else begin
			stream_q.push_back({masked, LEN_EXT64});
			for (int i = 7; i >= 0; i--)
				stream_q.push_back(8'(64'(len) >> (8 * i)));
		end
		if (masked)
			for (int i = 3; i >= 0; i--)
				stream_q.push_back(8'(key >> (8 * i)));
		repeat (len) stream_q.push_back(8'($urandom));
	endtask

	// ------------------------------------------------------------------------
	// Result side: stall at random from the falling edge, check at the rising
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= SHOWN_ERRORS)
			$display("%0t ns: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	initial begin : result_pacing
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			pop <= !stall_now();
		end
	end

	always @(posedge clk) begin : result_check
		frame_result_t want;
		if (arst_n && pop && !empty) begin
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("result with nothing due: kind %0d byte %0h",
					result_kind, payload_byte));
			end else begin
				want = results_due.pop_front();
				check_field("result_kind", 8'(result_kind), 8'(want.kind));
				check_field("payload_byte", payload_byte, want.data);
				check_field("frame_opcode", 8'(frame_opcode), 8'(want.opcode));
				check_field("final_fragment", 8'(final_fragment), 8'(want.fin));
				check_field("last_of_frame", 8'(last_of_frame), 8'(want.last));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin : stimulus
		logic [CFG_W-1:0] phase_limit [N_PHASES];
		int unsigned      cap;
		int unsigned      n_bytes;
		int unsigned      tail_lo;
		int unsigned      tail_hi;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows run under the limit left by reset
		for (int i = 0; i < DIRECTED_END; i++)
			send_byte(stim_table[i].b, stim_table[i].mode, stim_table[i].given);
		drain_results();

		// limits per phase: both register extremes, the build limit itself,
		// zero and one, and a few drawn at random
		phase_limit[0] = '1;
		phase_limit[1] = '0;
		phase_limit[2] = 21'd1;
		phase_limit[3] = 21'($urandom_range(2, 30));
		phase_limit[4] = 21'(MAX_LEN);
		phase_limit[5] = 21'($urandom);
		phase_limit[6] = 21'($urandom_range(126, 400));
		phase_limit[7] = '1;

		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_limit(phase_limit[ph]);
			steady = (ph == STEADY_PHASE);
			// Phases split frames at arbitrary bytes, so a frame built now may
			// complete its length under the next limit: respect both.
			cap = applied_limit(phase_limit[ph]);
			if (ph + 1 < N_PHASES && applied_limit(phase_limit[ph + 1]) < cap)
				cap = applied_limit(phase_limit[ph + 1]);
			while (stream_q.size() < PHASE_BYTES)
				build_frame(cap);
			n_bytes = (ph == N_PHASES - 1) ? stream_q.size() : PHASE_BYTES;
			repeat (n_bytes) send_byte(stream_q.pop_front(), EXP_MODEL, NO_RESULT);
			drain_results();
		end
		steady = 1'b0;

		// close with one error frame and a few bytes the block must swallow
		if ($urandom_range(1) == 1) begin
			tail_lo = DIRECTED_END;
			tail_hi = RSV_TAIL_END;
		end else begin
			tail_lo = RSV_TAIL_END;
			tail_hi = TABLE_ROWS;
		end
		for (int i = tail_lo; i < tail_hi; i++)
			send_byte(stim_table[i].b, stim_table[i].mode, stim_table[i].given);
		drain_results();

		if (mismatch_count == 0 && results_due.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin : watchdog
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
